[hdl/eight_bit_cpu_execute_unit_core_defines.svh]
// Assertion macros for the checker file.
`ifndef EIGHT_BIT_CPU_EXECUTE_UNIT_CORE_DEFINES_SVH
`define EIGHT_BIT_CPU_EXECUTE_UNIT_CORE_DEFINES_SVH

// Checked only while out of reset.
`define ECU_CHK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("execute unit check failed");

// Checked at every edge, reset included.
`define ECU_CHK_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("execute unit reset check failed");

`endif

[hdl/ecu_pkg.sv]
`timescale 1ns / 1ps
package ecu_pkg;

  // Operation codes
  typedef enum logic [5:0] {
    OP_LDA, OP_LDX, OP_LDY, OP_STA, OP_STX, OP_STY, OP_ADC, OP_SBC, OP_AND, OP_ORA,
    OP_EOR, OP_CMP, OP_CPX, OP_CPY, OP_BIT, OP_ASL, OP_LSR, OP_ROL, OP_ROR, OP_INC,
    OP_DEC, OP_INX, OP_INY, OP_DEX, OP_DEY, OP_TAX, OP_TXA, OP_TAY, OP_TYA, OP_TSX,
    OP_TXS, OP_PHA, OP_PLA, OP_PHP, OP_PLP, OP_CLC, OP_SEC, OP_CLI, OP_SEI, OP_CLV,
    OP_CLD, OP_SED, OP_JMP, OP_JMPI, OP_JSR, OP_RTS, OP_BRK, OP_RTI, OP_NOP, OP_BRA
  } op_t;

  // Status bit positions
  localparam int unsigned FB_C = 0;
  localparam int unsigned FB_Z = 1;
  localparam int unsigned FB_I = 2;
  localparam int unsigned FB_D = 3;
  localparam int unsigned FB_B = 4;
  localparam int unsigned FB_U = 5;
  localparam int unsigned FB_V = 6;
  localparam int unsigned FB_N = 7;

  // Branch flag selects
  localparam logic [1:0] BR_N = 2'd0;
  localparam logic [1:0] BR_V = 2'd1;
  localparam logic [1:0] BR_C = 2'd2;
  localparam logic [1:0] BR_Z = 2'd3;

  localparam logic [7:0] SP_RESET = 8'hFD;
  localparam logic [7:0] P_RESET  = 8'h24;

  typedef struct packed {
    logic       branch_sense;
    logic [1:0] branch_flag;
    logic [15:0] next_pc;
    logic [15:0] jump_target;
    logic [7:0] operand;
    logic [5:0] op;
  } item_t;

  typedef struct packed {
    logic [15:0] pc_out;
    logic [7:0] status_out;
    logic [7:0] sp_out;
    logic [7:0] y_out;
    logic [7:0] x_out;
    logic [7:0] acc_out;
    logic       write_valid;
    logic [7:0] write_data;
  } result_t;

endpackage

[hdl/ecu_ram.sv]
`timescale 1ns / 1ps
// Single-port synchronous RAM, registered read.
module ecu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

[hdl/eight_bit_cpu_execute_unit_core.sv]
`timescale 1ns / 1ps
// Execute unit of an 8-bit CPU, one decoded instruction per item.
// in_*  : instruction items; out_* : one result item per instruction with the
//         write-back byte and the full register state after it.
// cfg_* : write of the break vector, taken any cycle (cfg_ready is always 1).
// Registers live in flops; the stack is a 256 x 8 single-port RAM with a
// registered read, one access per cycle.
// Register and ALU ops and PHA/PHP end in their first step. The stack port
// sets the other steps: JSR and BRK push a byte per step, PLA, PLP, RTS and
// RTI read a byte per step and end with a step that takes the last byte read.
// A result is registered to out_* at the item's final step and a new item is
// taken in that same cycle, so simple ops stream at 1/cycle unless stalled.
// When the receiver stalls, the result is held and the next item waits
// at its final step until the output register frees.
// Reset (rst_n low, synchronous) clears A, X, Y, PC and the break vector,
// sets SP to FD and status to 24, and drops out_tvalid. Stack contents are
// not cleared.
module eight_bit_cpu_execute_unit_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // op[5:0], operand[13:6], jump_target[29:14], next_pc[45:30],
  // branch_flag[47:46], branch_sense[48], zero fill
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // write_data[7:0], write_valid[8], acc_out[16:9], x_out[24:17],
  // y_out[32:25], sp_out[40:33], status_out[48:41], pc_out[64:49], zero fill
  output logic [71:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  ecu_pkg::item_t   item_r;
  ecu_pkg::result_t res;
  ecu_pkg::result_t out_r;
  ecu_pkg::op_t     op;

  logic [15:0] brk_vec_r;
  logic [7:0]  acc_r, x_r, y_r, sp_r, p_r;
  logic [15:0] pc_r;
  logic        busy_r, out_valid_r;
  logic [1:0]  st_r;
  logic [7:0]  cap1_r, cap2_r;

  logic [1:0]  last_st;
  logic        is_push, is_pull, is_last, out_free, act, fin, accept;
  logic [7:0]  push_val, rdata, ram_addr, sp_nxt, m;
  logic [15:0] ret_addr;

  assign op        = ecu_pkg::op_t'(item_r.op);
  assign m         = item_r.operand;
  assign ret_addr  = item_r.next_pc - 16'd1;
  assign cfg_ready = 1'b1;

  // Stack step plan per op
  always_comb begin
    last_st  = 2'd0;
    is_push  = 1'b0;
    is_pull  = 1'b0;
    push_val = acc_r;
    case (op)
      ecu_pkg::OP_PHA: begin is_push = 1'b1; push_val = acc_r; end
      ecu_pkg::OP_PHP: begin is_push = 1'b1; push_val = p_r | 8'h30; end
      ecu_pkg::OP_JSR: begin
        is_push = 1'b1; last_st = 2'd1;
        push_val = (st_r == 2'd0) ? ret_addr[15:8] : ret_addr[7:0];
      end
      ecu_pkg::OP_BRK: begin
        is_push = 1'b1; last_st = 2'd2;
        case (st_r)
          2'd0:    push_val = item_r.next_pc[15:8];
          2'd1:    push_val = item_r.next_pc[7:0];
          default: push_val = p_r | 8'h30;
        endcase
      end
      ecu_pkg::OP_PLA: begin is_pull = 1'b1; last_st = 2'd1; end
      ecu_pkg::OP_PLP: begin is_pull = 1'b1; last_st = 2'd1; end
      ecu_pkg::OP_RTS: begin is_pull = 1'b1; last_st = 2'd2; end
      ecu_pkg::OP_RTI: begin is_pull = 1'b1; last_st = 2'd3; end
      default: ;
    endcase
  end

  assign is_last   = (st_r == last_st);
  assign out_free  = ~out_valid_r | out_tready;
  assign act       = busy_r & (~is_last | out_free);
  assign fin       = busy_r & is_last & out_free;
  assign in_tready = ~busy_r | fin;
  assign accept    = in_tvalid & in_tready;

  // Stack RAM: pushes write at sp, pulls read at sp+1 (except on a
  // pull's final step, which only takes the data)
  assign ram_addr = is_push ? sp_r : sp_r + 8'd1;

  ecu_ram #(.WIDTH(8), .DEPTH(256)) u_stack (
    .clk   (clk),
    .en    (act & (is_push | (is_pull & ~is_last))),
    .we    (is_push),
    .addr  (ram_addr),
    .wdata (push_val),
    .rdata (rdata)
  );

  // Stack pointer per step
  always_comb begin
    sp_nxt = sp_r;
    if (act & is_push) begin
      sp_nxt = sp_r - 8'd1;
    end else if (act & is_pull & ~is_last) begin
      sp_nxt = sp_r + 8'd1;
    end else if (fin & (op == ecu_pkg::OP_TXS)) begin
      sp_nxt = x_r;
    end
  end

  // Instruction result, valid on the final step
  always_comb begin
    logic [8:0] sum;
    logic [7:0] b, r, p;
    logic       bsel;
    res             = '0;
    res.acc_out     = acc_r;
    res.x_out       = x_r;
    res.y_out       = y_r;
    res.sp_out      = sp_nxt;
    res.pc_out      = item_r.next_pc;
    p               = p_r;
    r               = 8'd0;
    b               = (op == ecu_pkg::OP_SBC) ? ~m : m;
    sum             = {1'b0, acc_r} + {1'b0, b} + {8'd0, p_r[ecu_pkg::FB_C]};
    case (item_r.branch_flag)
      ecu_pkg::BR_N: bsel = p_r[ecu_pkg::FB_N];
      ecu_pkg::BR_V: bsel = p_r[ecu_pkg::FB_V];
      ecu_pkg::BR_C: bsel = p_r[ecu_pkg::FB_C];
      default:       bsel = p_r[ecu_pkg::FB_Z];
    endcase
    case (op)
      ecu_pkg::OP_LDA: begin res.acc_out = m; r = m; end
      ecu_pkg::OP_LDX: begin res.x_out = m; r = m; end
      ecu_pkg::OP_LDY: begin res.y_out = m; r = m; end
      ecu_pkg::OP_STA: begin res.write_data = acc_r; res.write_valid = 1'b1; end
      ecu_pkg::OP_STX: begin res.write_data = x_r; res.write_valid = 1'b1; end
      ecu_pkg::OP_STY: begin res.write_data = y_r; res.write_valid = 1'b1; end
      ecu_pkg::OP_ADC, ecu_pkg::OP_SBC: begin
        r = sum[7:0]; res.acc_out = r;
        p[ecu_pkg::FB_C] = sum[8];
        p[ecu_pkg::FB_V] = ~(acc_r[7] ^ b[7]) & (acc_r[7] ^ r[7]);
      end
      ecu_pkg::OP_AND: begin r = acc_r & m; res.acc_out = r; end
      ecu_pkg::OP_ORA: begin r = acc_r | m; res.acc_out = r; end
      ecu_pkg::OP_EOR: begin r = acc_r ^ m; res.acc_out = r; end
      ecu_pkg::OP_CMP: begin r = acc_r - m; p[ecu_pkg::FB_C] = (acc_r >= m); end
      ecu_pkg::OP_CPX: begin r = x_r - m; p[ecu_pkg::FB_C] = (x_r >= m); end
      ecu_pkg::OP_CPY: begin r = y_r - m; p[ecu_pkg::FB_C] = (y_r >= m); end
      ecu_pkg::OP_BIT: begin r = {m[7], 6'd1, ~|(acc_r & m)}; end
      ecu_pkg::OP_ASL, ecu_pkg::OP_ROL: begin
        r = {m[6:0], (op == ecu_pkg::OP_ROL) & p_r[ecu_pkg::FB_C]};
        p[ecu_pkg::FB_C] = m[7];
        res.write_data = r; res.write_valid = 1'b1;
      end
      ecu_pkg::OP_LSR, ecu_pkg::OP_ROR: begin
        r = {(op == ecu_pkg::OP_ROR) & p_r[ecu_pkg::FB_C], m[7:1]};
        p[ecu_pkg::FB_C] = m[0];
        res.write_data = r; res.write_valid = 1'b1;
      end
      ecu_pkg::OP_INC: begin r = m + 8'd1; res.write_data = r; res.write_valid = 1'b1; end
      ecu_pkg::OP_DEC: begin r = m - 8'd1; res.write_data = r; res.write_valid = 1'b1; end
      ecu_pkg::OP_INX: begin r = x_r + 8'd1; res.x_out = r; end
      ecu_pkg::OP_INY: begin r = y_r + 8'd1; res.y_out = r; end
      ecu_pkg::OP_DEX: begin r = x_r - 8'd1; res.x_out = r; end
      ecu_pkg::OP_DEY: begin r = y_r - 8'd1; res.y_out = r; end
      ecu_pkg::OP_TAX: begin r = acc_r; res.x_out = r; end
      ecu_pkg::OP_TXA: begin r = x_r; res.acc_out = r; end
      ecu_pkg::OP_TAY: begin r = acc_r; res.y_out = r; end
      ecu_pkg::OP_TYA: begin r = y_r; res.acc_out = r; end
      ecu_pkg::OP_TSX: begin r = sp_r; res.x_out = r; end
      ecu_pkg::OP_PLA: begin r = rdata; res.acc_out = r; end
      ecu_pkg::OP_PLP: p = rdata;
      ecu_pkg::OP_CLC: p[ecu_pkg::FB_C] = 1'b0;
      ecu_pkg::OP_SEC: p[ecu_pkg::FB_C] = 1'b1;
      ecu_pkg::OP_CLI: p[ecu_pkg::FB_I] = 1'b0;
      ecu_pkg::OP_SEI: p[ecu_pkg::FB_I] = 1'b1;
      ecu_pkg::OP_CLV: p[ecu_pkg::FB_V] = 1'b0;
      ecu_pkg::OP_CLD: p[ecu_pkg::FB_D] = 1'b0;
      ecu_pkg::OP_SED: p[ecu_pkg::FB_D] = 1'b1;
      ecu_pkg::OP_JMP, ecu_pkg::OP_JMPI: res.pc_out = item_r.jump_target;
      ecu_pkg::OP_JSR: res.pc_out = item_r.jump_target;
      ecu_pkg::OP_RTS: res.pc_out = {rdata, cap1_r} + 16'd1;
      ecu_pkg::OP_BRK: begin p[ecu_pkg::FB_I] = 1'b1; res.pc_out = brk_vec_r; end
      ecu_pkg::OP_RTI: begin p = cap1_r; res.pc_out = {rdata, cap2_r}; end
      ecu_pkg::OP_BRA: begin
        if (bsel == item_r.branch_sense) begin
          res.pc_out = item_r.next_pc + {{8{m[7]}}, m};
        end
      end
      default: ;
    endcase
    // N and Z follow r for the ops that set them
    case (op)
      ecu_pkg::OP_STA, ecu_pkg::OP_STX, ecu_pkg::OP_STY, ecu_pkg::OP_TXS,
      ecu_pkg::OP_PHA, ecu_pkg::OP_PHP, ecu_pkg::OP_PLP, ecu_pkg::OP_CLC,
      ecu_pkg::OP_SEC, ecu_pkg::OP_CLI, ecu_pkg::OP_SEI, ecu_pkg::OP_CLV,
      ecu_pkg::OP_CLD, ecu_pkg::OP_SED, ecu_pkg::OP_JMP, ecu_pkg::OP_JMPI,
      ecu_pkg::OP_JSR, ecu_pkg::OP_RTS, ecu_pkg::OP_BRK, ecu_pkg::OP_RTI,
      ecu_pkg::OP_NOP, ecu_pkg::OP_BRA: ;
      ecu_pkg::OP_BIT: begin
        p[ecu_pkg::FB_N] = m[7];
        p[ecu_pkg::FB_V] = m[6];
        p[ecu_pkg::FB_Z] = r[0];
      end
      default: begin
        if (item_r.op <= 6'(ecu_pkg::OP_BRA)) begin
          p[ecu_pkg::FB_N] = r[7];
          p[ecu_pkg::FB_Z] = (r == 8'd0);
        end
      end
    endcase
    p[ecu_pkg::FB_U] = 1'b1;
    p[ecu_pkg::FB_B] = 1'b0;
    res.status_out   = p;
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      st_r        <= 2'd0;
      out_valid_r <= 1'b0;
      brk_vec_r   <= 16'd0;
      acc_r       <= 8'd0;
      x_r         <= 8'd0;
      y_r         <= 8'd0;
      sp_r        <= ecu_pkg::SP_RESET;
      p_r         <= ecu_pkg::P_RESET;
      pc_r        <= 16'd0;
    end else begin
      if (cfg_valid) begin
        brk_vec_r <= cfg_data;
      end
      sp_r <= sp_nxt;
      if (accept) begin
        busy_r <= 1'b1;
        st_r   <= 2'd0;
      end else if (fin) begin
        busy_r <= 1'b0;
      end else if (act) begin
        st_r <= st_r + 2'd1;
      end
      if (fin) begin
        out_valid_r <= 1'b1;
        acc_r       <= res.acc_out;
        x_r         <= res.x_out;
        y_r         <= res.y_out;
        p_r         <= res.status_out;
        pc_r        <= res.pc_out;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_tdata[48:0];
    end
    if (act & (st_r == 2'd1)) begin
      cap1_r <= rdata;
    end
    if (act & (st_r == 2'd2)) begin
      cap2_r <= rdata;
    end
    if (fin) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_r.pc_out[15:0] & pc_r | out_r.pc_out,
                       out_r.status_out, out_r.sp_out, out_r.y_out, out_r.x_out,
                       out_r.acc_out, out_r.write_valid, out_r.write_data};

endmodule

[hdl/ecu_checker.sv]
`timescale 1ns / 1ps
`include "eight_bit_cpu_execute_unit_core_defines.svh"
// Port-level checks of the execute unit.
module ecu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);

  // A stalled result holds
  `ECU_CHK(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
  // No result right after reset
  `ECU_CHK_RST(a_rst_idle, !rst_n |=> !out_tvalid)
  // Status shows bit 5 set and B clear
  `ECU_CHK(a_status_fix, out_tvalid |-> out_tdata[46] && !out_tdata[45])
  // No write-back byte without a write
  `ECU_CHK(a_wdata_zero, out_tvalid && !out_tdata[8] |-> out_tdata[7:0] == 8'd0)

endmodule

bind eight_bit_cpu_execute_unit_core ecu_checker u_ecu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[verif/eight_bit_cpu_execute_unit_core_test.sv]
`timescale 1ns / 1ps
module eight_bit_cpu_execute_unit_core_test;

  localparam int unsigned STALL_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  eight_bit_cpu_execute_unit_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predicted CPU state
  logic [7:0]  cpu_a, cpu_x, cpu_y, cpu_sp, cpu_p;
  logic [15:0] cpu_pc, brk_vec;
  logic [7:0]  stack_img [256];
  bit          stack_written [256];
  ecu_pkg::result_t pending_results [$];
  bit          failed = 0;
  bit          idle_on = 0;
  int unsigned ready_hold = 0;
  int unsigned quiet_cycles = 0;

  // Flag helpers
  task automatic upd_nz(input logic [7:0] v);
    cpu_p[ecu_pkg::FB_N] = v[7];
    cpu_p[ecu_pkg::FB_Z] = (v == 8'h00);
  endtask

  task automatic add_with_carry(input logic [7:0] mm);
    logic [8:0] sum;
    logic [7:0] r;
    sum = {1'b0, cpu_a} + {1'b0, mm} + {8'h00, cpu_p[ecu_pkg::FB_C]};
    r = sum[7:0];
    cpu_p[ecu_pkg::FB_C] = sum[8];
    cpu_p[ecu_pkg::FB_V] = (~(cpu_a[7] ^ mm[7])) & (cpu_a[7] ^ r[7]);
    cpu_a = r;
    upd_nz(r);
  endtask

  task automatic compare_reg(input logic [7:0] rv, input logic [7:0] mm);
    cpu_p[ecu_pkg::FB_C] = (rv >= mm);
    upd_nz(rv - mm);
  endtask

  task automatic push_stack(input logic [7:0] v);
    stack_img[cpu_sp] = v;
    stack_written[cpu_sp] = 1;
    cpu_sp = cpu_sp - 8'd1;
  endtask

  task automatic pull_stack(output logic [7:0] v);
    cpu_sp = cpu_sp + 8'd1;
    v = stack_img[cpu_sp];
  endtask

  function automatic bit stack_ready(input int unsigned n);
    logic [7:0] s;
    s = cpu_sp;
    for (int i = 0; i < n; i++) begin
      s = s + 8'd1;
      if (!stack_written[s]) return 0;
    end
    return 1;
  endfunction

  // Execute one instruction on the predicted state and queue its result
  task automatic execute_instr(input ecu_pkg::item_t it);
    logic [7:0]  m, r, lo, hi, wd;
    logic        wv, taken;
    logic [15:0] npc, ret;
    ecu_pkg::result_t e;
    m = it.operand; wd = 8'h00; wv = 1'b0; npc = it.next_pc;
    case (it.op)
      ecu_pkg::OP_LDA: begin cpu_a = m; upd_nz(m); end
      ecu_pkg::OP_LDX: begin cpu_x = m; upd_nz(m); end
      ecu_pkg::OP_LDY: begin cpu_y = m; upd_nz(m); end
      ecu_pkg::OP_STA: begin wd = cpu_a; wv = 1; end
      ecu_pkg::OP_STX: begin wd = cpu_x; wv = 1; end
      ecu_pkg::OP_STY: begin wd = cpu_y; wv = 1; end
      ecu_pkg::OP_ADC: add_with_carry(m);
      ecu_pkg::OP_SBC: add_with_carry(~m);
      ecu_pkg::OP_AND: begin cpu_a = cpu_a & m; upd_nz(cpu_a); end
      ecu_pkg::OP_ORA: begin cpu_a = cpu_a | m; upd_nz(cpu_a); end
      ecu_pkg::OP_EOR: begin cpu_a = cpu_a ^ m; upd_nz(cpu_a); end
      ecu_pkg::OP_CMP: compare_reg(cpu_a, m);
      ecu_pkg::OP_CPX: compare_reg(cpu_x, m);
      ecu_pkg::OP_CPY: compare_reg(cpu_y, m);
      ecu_pkg::OP_BIT: begin
        cpu_p[ecu_pkg::FB_Z] = ((cpu_a & m) == 8'h00);
        cpu_p[ecu_pkg::FB_N] = m[7];
        cpu_p[ecu_pkg::FB_V] = m[6];
      end
      ecu_pkg::OP_ASL: begin
        r = {m[6:0], 1'b0}; cpu_p[ecu_pkg::FB_C] = m[7]; upd_nz(r); wd = r; wv = 1;
      end
      ecu_pkg::OP_ROL: begin
        r = {m[6:0], cpu_p[ecu_pkg::FB_C]}; cpu_p[ecu_pkg::FB_C] = m[7];
        upd_nz(r); wd = r; wv = 1;
      end
      ecu_pkg::OP_LSR: begin
        r = {1'b0, m[7:1]}; cpu_p[ecu_pkg::FB_C] = m[0]; upd_nz(r); wd = r; wv = 1;
      end
      ecu_pkg::OP_ROR: begin
        r = {cpu_p[ecu_pkg::FB_C], m[7:1]}; cpu_p[ecu_pkg::FB_C] = m[0];
        upd_nz(r); wd = r; wv = 1;
      end
      ecu_pkg::OP_INC: begin r = m + 8'd1; upd_nz(r); wd = r; wv = 1; end
      ecu_pkg::OP_DEC: begin r = m - 8'd1; upd_nz(r); wd = r; wv = 1; end
      ecu_pkg::OP_INX: begin cpu_x = cpu_x + 8'd1; upd_nz(cpu_x); end
      ecu_pkg::OP_INY: begin cpu_y = cpu_y + 8'd1; upd_nz(cpu_y); end
      ecu_pkg::OP_DEX: begin cpu_x = cpu_x - 8'd1; upd_nz(cpu_x); end
      ecu_pkg::OP_DEY: begin cpu_y = cpu_y - 8'd1; upd_nz(cpu_y); end
      ecu_pkg::OP_TAX: begin cpu_x = cpu_a; upd_nz(cpu_x); end
      ecu_pkg::OP_TXA: begin cpu_a = cpu_x; upd_nz(cpu_a); end
      ecu_pkg::OP_TAY: begin cpu_y = cpu_a; upd_nz(cpu_y); end
      ecu_pkg::OP_TYA: begin cpu_a = cpu_y; upd_nz(cpu_a); end
      ecu_pkg::OP_TSX: begin cpu_x = cpu_sp; upd_nz(cpu_x); end
      ecu_pkg::OP_TXS: cpu_sp = cpu_x;
      ecu_pkg::OP_PHA: push_stack(cpu_a);
      ecu_pkg::OP_PLA: begin pull_stack(cpu_a); upd_nz(cpu_a); end
      ecu_pkg::OP_PHP: push_stack(cpu_p | 8'h30);
      ecu_pkg::OP_PLP: pull_stack(cpu_p);
      ecu_pkg::OP_CLC: cpu_p[ecu_pkg::FB_C] = 0;
      ecu_pkg::OP_SEC: cpu_p[ecu_pkg::FB_C] = 1;
      ecu_pkg::OP_CLI: cpu_p[ecu_pkg::FB_I] = 0;
      ecu_pkg::OP_SEI: cpu_p[ecu_pkg::FB_I] = 1;
      ecu_pkg::OP_CLV: cpu_p[ecu_pkg::FB_V] = 0;
      ecu_pkg::OP_CLD: cpu_p[ecu_pkg::FB_D] = 0;
      ecu_pkg::OP_SED: cpu_p[ecu_pkg::FB_D] = 1;
      ecu_pkg::OP_JMP, ecu_pkg::OP_JMPI: npc = it.jump_target;
      ecu_pkg::OP_JSR: begin
        ret = it.next_pc - 16'd1;
        push_stack(ret[15:8]);
        push_stack(ret[7:0]);
        npc = it.jump_target;
      end
      ecu_pkg::OP_RTS: begin pull_stack(lo); pull_stack(hi); npc = {hi, lo} + 16'd1; end
      ecu_pkg::OP_BRK: begin
        push_stack(it.next_pc[15:8]);
        push_stack(it.next_pc[7:0]);
        push_stack(cpu_p | 8'h30);
        cpu_p[ecu_pkg::FB_I] = 1;
        npc = brk_vec;
      end
      ecu_pkg::OP_RTI: begin
        pull_stack(cpu_p); pull_stack(lo); pull_stack(hi); npc = {hi, lo};
      end
      ecu_pkg::OP_BRA: begin
        case (it.branch_flag)
          ecu_pkg::BR_N: taken = cpu_p[ecu_pkg::FB_N];
          ecu_pkg::BR_V: taken = cpu_p[ecu_pkg::FB_V];
          ecu_pkg::BR_C: taken = cpu_p[ecu_pkg::FB_C];
          default: taken = cpu_p[ecu_pkg::FB_Z];
        endcase
        if (taken == it.branch_sense) npc = it.next_pc + {{8{m[7]}}, m};
      end
      default: ;
    endcase
    // bit 5 reads one, B reads zero in the live register
    cpu_p[ecu_pkg::FB_U] = 1;
    cpu_p[ecu_pkg::FB_B] = 0;
    cpu_pc = npc;
    e.write_data = wd; e.write_valid = wv;
    e.acc_out = cpu_a; e.x_out = cpu_x; e.y_out = cpu_y;
    e.sp_out = cpu_sp; e.status_out = cpu_p; e.pc_out = cpu_pc;
    pending_results.push_back(e);
  endtask

  // Send one item, predict on acceptance; returns at the accepting edge
  task automatic send_instr(input ecu_pkg::item_t it);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_tdata <= {7'b0, it};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    execute_instr(it);
  endtask

  task automatic send_op(input ecu_pkg::op_t op, input logic [7:0] m);
    ecu_pkg::item_t it;
    it.op = op; it.operand = m;
    it.jump_target = 16'($urandom); it.next_pc = 16'($urandom);
    it.branch_flag = 2'($urandom); it.branch_sense = 1'($urandom);
    send_instr(it);
  endtask

  task automatic send_branch(input logic [1:0] bf, input logic bs, input logic [7:0] m,
                             input logic [15:0] nxt);
    ecu_pkg::item_t it;
    it.op = ecu_pkg::OP_BRA; it.operand = m; it.jump_target = 16'($urandom);
    it.next_pc = nxt; it.branch_flag = bf; it.branch_sense = bs;
    send_instr(it);
  endtask

  // Wait until the block is idle, then write the break vector
  task automatic write_vector(input logic [15:0] v);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    brk_vec = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver stalls in bursts during the random idle test
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      ready_hold = $urandom_range(0, 14);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Result checker
  always @(posedge clk) begin
    ecu_pkg::result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[64:0];
      if (pending_results.size() == 0) begin
        $error("unexpected result item %h", got);
        failed = 1;
      end else begin
        want = pending_results.pop_front();
        if (got.write_data !== want.write_data) begin
          $error("write_data exp %h got %h", want.write_data, got.write_data); failed = 1;
        end
        if (got.write_valid !== want.write_valid) begin
          $error("write_valid exp %h got %h", want.write_valid, got.write_valid); failed = 1;
        end
        if (got.acc_out !== want.acc_out) begin
          $error("acc_out exp %h got %h", want.acc_out, got.acc_out); failed = 1;
        end
        if (got.x_out !== want.x_out) begin
          $error("x_out exp %h got %h", want.x_out, got.x_out); failed = 1;
        end
        if (got.y_out !== want.y_out) begin
          $error("y_out exp %h got %h", want.y_out, got.y_out); failed = 1;
        end
        if (got.sp_out !== want.sp_out) begin
          $error("sp_out exp %h got %h", want.sp_out, got.sp_out); failed = 1;
        end
        if (got.status_out !== want.status_out) begin
          $error("status_out exp %h got %h", want.status_out, got.status_out); failed = 1;
        end
        if (got.pc_out !== want.pc_out) begin
          $error("pc_out exp %h got %h", want.pc_out, got.pc_out); failed = 1;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Reset state shows through a NOP; unused code acts as NOP
  task automatic test_reset_state();
    send_op(ecu_pkg::OP_NOP, 8'h00);
    send_op(ecu_pkg::op_t'(6'd63), 8'hFF);
  endtask

  // Loads, ALU and flag edge cases
  task automatic test_alu_directed();
    send_op(ecu_pkg::OP_LDA, 8'h00);
    send_op(ecu_pkg::OP_LDX, 8'hFF);
    send_op(ecu_pkg::OP_LDY, 8'h80);
    send_op(ecu_pkg::OP_LDA, 8'h7F);
    send_op(ecu_pkg::OP_ADC, 8'h01);   // signed overflow
    send_op(ecu_pkg::OP_SBC, 8'hFF);   // borrow path
    send_op(ecu_pkg::OP_CMP, 8'h80);   // equal compare
    send_op(ecu_pkg::OP_BIT, 8'hC0);
    send_op(ecu_pkg::OP_SEC, 8'h00);
    send_op(ecu_pkg::OP_ROR, 8'h01);   // carry in and out
    send_op(ecu_pkg::OP_ROL, 8'h80);
    send_op(ecu_pkg::OP_INC, 8'hFF);   // wraps to zero
    send_op(ecu_pkg::OP_DEC, 8'h00);
    send_op(ecu_pkg::OP_STX, 8'h00);
  endtask

  // Stack, subroutine, break and branches
  task automatic test_flow_directed();
    send_op(ecu_pkg::OP_PHA, 8'h00);
    send_op(ecu_pkg::OP_PHP, 8'h00);   // pushed copy carries B
    send_op(ecu_pkg::OP_PLP, 8'h00);
    send_op(ecu_pkg::OP_PLA, 8'h00);
    send_op(ecu_pkg::OP_JSR, 8'h00);
    send_op(ecu_pkg::OP_RTS, 8'h00);
    send_op(ecu_pkg::OP_BRK, 8'h00);
    send_op(ecu_pkg::OP_RTI, 8'h00);
    send_branch(ecu_pkg::BR_Z, 1'b0, 8'h80, 16'h0010);  // backward wrap below zero
    send_branch(ecu_pkg::BR_C, 1'b1, 8'h7F, 16'hFFF0);  // forward wrap above top
    send_branch(ecu_pkg::BR_N, 1'b1, 8'h05, 16'h1234);
  endtask

  // Random item, pulls only from entries that were pushed
  task automatic send_random_instr();
    ecu_pkg::item_t it;
    it = 49'($urandom) | (49'($urandom) << 32);
    it.op = 6'($urandom_range(0, 63));
    if ($urandom_range(0, 9) == 0) it.op = ecu_pkg::OP_TXS;
    case (it.op)
      ecu_pkg::OP_PLA: if (!stack_ready(1)) it.op = ecu_pkg::OP_PHA;
      ecu_pkg::OP_PLP: if (!stack_ready(1)) it.op = ecu_pkg::OP_PHP;
      ecu_pkg::OP_RTS: if (!stack_ready(2)) it.op = ecu_pkg::OP_JSR;
      ecu_pkg::OP_RTI: if (!stack_ready(3)) it.op = ecu_pkg::OP_BRK;
      default: ;
    endcase
    // once in a while build a call and its return back to back
    if (it.op == ecu_pkg::OP_JSR && $urandom_range(0, 1) == 0) begin
      send_instr(it);
      it.op = ecu_pkg::OP_RTS;
    end else if (it.op == ecu_pkg::OP_BRK && $urandom_range(0, 1) == 0) begin
      send_instr(it);
      it.op = ecu_pkg::OP_RTI;
    end
    send_instr(it);
  endtask

  task automatic test_random_idle(input int unsigned n);
    idle_on = 1;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 150 == 149) write_vector(16'($urandom));
      send_random_instr();
    end
  endtask

  task automatic test_random_stream(input int unsigned n);
    idle_on = 0;
    for (int unsigned i = 0; i < n; i++) send_random_instr();
  endtask

  initial begin
    cpu_a = 0; cpu_x = 0; cpu_y = 0; cpu_sp = ecu_pkg::SP_RESET; cpu_p = ecu_pkg::P_RESET;
    cpu_pc = 0; brk_vec = 0;
    foreach (stack_written[i]) stack_written[i] = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    write_vector(16'hFFFF);
    test_alu_directed();
    test_flow_directed();
    write_vector(16'h0000);
    test_flow_directed();
    write_vector(16'hC3A5);
    test_random_idle(410);
    test_random_stream(100);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (!failed) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[eight_bit_cpu_execute_unit_core.f]
+incdir+hdl
hdl/ecu_pkg.sv
hdl/ecu_ram.sv
hdl/eight_bit_cpu_execute_unit_core.sv
hdl/ecu_checker.sv
verif/eight_bit_cpu_execute_unit_core_test.sv
